>>> src/bhq_pkg.sv
// bhq_pkg: types and constants shared by the button history block,
// its channel interfaces and its bench. Depends on nothing.
package bhq_pkg;

	localparam int BTN_W  = 11;
	localparam int SEL_W  = 3;
	localparam int AGO_W  = 6;
	localparam int HOLD_W = 7;
	localparam int BIT_W  = 4;

	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// snapshot bit positions
	localparam logic [BIT_W-1:0] BTN_LEFT    = 4'd0;
	localparam logic [BIT_W-1:0] BTN_RIGHT   = 4'd1;
	localparam logic [BIT_W-1:0] BTN_UP      = 4'd2;
	localparam logic [BIT_W-1:0] BTN_DOWN    = 4'd3;
	localparam logic [BIT_W-1:0] BTN_MOVE    = 4'd4;
	localparam logic [BIT_W-1:0] BTN_STANCE1 = 4'd9;
	localparam logic [BIT_W-1:0] BTN_STANCE2 = 4'd10;

	// control selector codes
	localparam logic [SEL_W-1:0] CTL_LEFT    = 3'd0;
	localparam logic [SEL_W-1:0] CTL_RIGHT   = 3'd1;
	localparam logic [SEL_W-1:0] CTL_DOWN    = 3'd2;
	localparam logic [SEL_W-1:0] CTL_UP      = 3'd3;
	localparam logic [SEL_W-1:0] CTL_MOVE    = 3'd4;
	localparam logic [SEL_W-1:0] CTL_STANCE1 = 3'd5;
	localparam logic [SEL_W-1:0] CTL_STANCE2 = 3'd6;

	typedef struct packed {
		logic              req_type;
		logic [BTN_W-1:0]  buttons;
		logic [SEL_W-1:0]  control_sel;
		logic [AGO_W-1:0]  frames_ago;
		logic [HOLD_W-1:0] hold_length;
	} in_item_t;

	typedef struct packed {
		logic             is_down;
		logic             was_pressed;
		logic             was_released;
		logic             was_held;
		logic [BTN_W-1:0] latest_buttons;
	} out_item_t;

	typedef struct packed {
		logic             ok;
		logic [BIT_W-1:0] idx;
	} ctl_bit_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} bhq_state_t;

	function automatic ctl_bit_t ctl_bit(input logic [SEL_W-1:0] sel);
		ctl_bit_t r;
		r.ok  = 1'b1;
		r.idx = BTN_LEFT;
		case (sel)
			CTL_LEFT:    r.idx = BTN_LEFT;
			CTL_RIGHT:   r.idx = BTN_RIGHT;
			CTL_DOWN:    r.idx = BTN_DOWN;
			CTL_UP:      r.idx = BTN_UP;
			CTL_MOVE:    r.idx = BTN_MOVE;
			CTL_STANCE1: r.idx = BTN_STANCE1;
			CTL_STANCE2: r.idx = BTN_STANCE2;
			default:     r.ok  = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> src/bhq_if.sv
// bhq_if: valid/ready channel interfaces for the request and result items.
// Depends on bhq_pkg for the payload types.
interface bhq_in_if;
	logic              valid;
	logic              ready;
	bhq_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bhq_out_if;
	logic               valid;
	logic               ready;
	bhq_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> src/button_history_edge_query.sv
// Channels: in_ch takes request items, out_ch gives result items, both valid/ready.
// A record item (req_type 0) stores its 11-bit snapshot at the write pointer,
// advances the pointer modulo DEPTH and gives no result.
// A query item (req_type 1) gives one result: is_down, was_pressed,
// was_released and was_held for the selected control at frames_ago back, plus
// the latest snapshot. The sequencer reads the history RAM one entry a cycle,
// N = max(2, hold_length) reads, through the single read port of the history
// RAM; it then passes ST_DRAIN and ST_FINISH, which loads the output register.
// in_ready is high only while no query is in progress; records go back to back.
// The result sits in an output register: a new record may be accepted while a
// result waits, and a query finished during a stall holds until out_ch.ready.
// Reset clears the write pointer, a fill count and the latest snapshot; history
// entries not yet written since reset read as zero through the fill count, so
// no clearing pass is needed and the block is ready right after reset.
// Depends on bhq_pkg, bhq_if and bhq_ram.
module button_history_edge_query #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	bhq_in_if.sink      in_ch,
	bhq_out_if.source   out_ch
);
	import bhq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int DW = ((AW > AGO_W) ? AW : AGO_W) + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [FW-1:0] FULL_CNT  = FW'(DEPTH);

	bhq_state_t state_q, state_d;

	logic [AW-1:0]     wp_q;
	logic [FW-1:0]     fill_q;
	logic [BTN_W-1:0]  latest_q;
	logic [AW-1:0]     addr_q;
	logic [HOLD_W-1:0] cnt_q;
	logic [HOLD_W-1:0] last_q;
	logic [HOLD_W-1:0] hold_q;
	ctl_bit_t          ctl_q;
	logic              rd_s1;
	logic [HOLD_W-1:0] k_s1;
	logic              ok_s1;
	logic              now_q;
	logic              prev_q;
	logic              held_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic              in_acc;
	logic              issue;
	logic              load_out;
	logic              rec_acc;
	logic              qry_acc;
	logic [AGO_W-1:0]  ago_mod;
	logic [DW-1:0]     start_diff;
	logic [AW-1:0]     start_addr;
	logic [BTN_W-1:0]  rdata;
	logic              cur_bit;
	logic              entry_ok;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign rec_acc = in_acc && (in_ch.data.req_type == REQ_RECORD);
	assign qry_acc = in_acc && (in_ch.data.req_type == REQ_QUERY);

	// frames_ago modulo DEPTH by restoring subtraction of DEPTH << s
	always_comb begin
		logic [31:0] x;
		x = 32'(in_ch.data.frames_ago);
		for (int s = AGO_W - 1; s >= 0; s--) begin
			if (x >= (32'(DEPTH) << s)) begin
				x = x - (32'(DEPTH) << s);
			end
		end
		ago_mod = AGO_W'(x);
	end

	always_comb begin
		start_diff = DW'(wp_q) - DW'(ago_mod);
		if (start_diff[DW-1]) begin
			start_diff = start_diff + DW'(DEPTH);
		end
		start_addr = AW'(start_diff);
	end

	// entries beyond the fill count were never written since reset
	assign entry_ok = (fill_q == FULL_CNT) || (FW'(addr_q) < fill_q);

	bhq_ram #(
		.WIDTH (BTN_W),
		.DEPTH (DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (rec_acc),
		.waddr (wp_q),
		.wdata (in_ch.data.buttons),
		.re    (issue),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign cur_bit = ok_s1 && ctl_q.ok && rdata[ctl_q.idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		issue       = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (qry_acc) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (cnt_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			fill_q      <= '0;
			latest_q    <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rec_acc) begin
				wp_q     <= (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
				latest_q <= in_ch.data.buttons;
				if (fill_q != FULL_CNT) begin
					fill_q <= fill_q + FW'(1);
				end
			end
			rd_s1 <= issue;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (qry_acc) begin
			addr_q <= start_addr;
			cnt_q  <= '0;
			hold_q <= in_ch.data.hold_length;
			last_q <= (in_ch.data.hold_length < HOLD_W'(2)) ? HOLD_W'(1)
			        : in_ch.data.hold_length - HOLD_W'(1);
			ctl_q  <= ctl_bit(in_ch.data.control_sel);
			held_q <= 1'b1;
		end
		if (issue) begin
			addr_q <= (addr_q == '0) ? LAST_ADDR : addr_q - AW'(1);
			cnt_q  <= cnt_q + HOLD_W'(1);
			k_s1   <= cnt_q;
			ok_s1  <= entry_ok;
		end
		if (rd_s1) begin
			if (k_s1 == '0) begin
				now_q <= cur_bit;
			end
			if (k_s1 == HOLD_W'(1)) begin
				prev_q <= cur_bit;
			end
			if ((k_s1 < hold_q) && !cur_bit) begin
				held_q <= 1'b0;
			end
		end
		if (load_out) begin
			out_q.is_down        <= now_q;
			out_q.was_pressed    <= now_q && !prev_q;
			out_q.was_released   <= !now_q && prev_q;
			out_q.was_held       <= held_q;
			out_q.latest_buttons <= latest_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

endmodule

>>> src/bhq_ram.sv
// bhq_ram: generic single-write, single-read synchronous RAM with a
// registered read port. Depends on nothing.
module bhq_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/bhq_checker.sv
// bhq_checker: port-level assertions for button_history_edge_query, bound
// to the top level. Depends on nothing beyond the top level's ports.
module bhq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_req_type,
	input logic out_valid,
	input logic out_ready,
	input logic out_is_down,
	input logic out_was_pressed,
	input logic out_was_released
);

	// a stalled result item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a query item drops in_ready in the cycle after it is accepted
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_req_type |=> !in_ready)
		else $error("ready right after a query item");

	// records go back to back
	a_record_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_req_type |=> in_ready)
		else $error("record item stalled the next item");

	// edge flags agree with the down flag
	a_edge_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_was_pressed || out_is_down)
			&& (!out_was_released || !out_is_down))
		else $error("edge flags contradict is_down");

endmodule

bind button_history_edge_query bhq_checker u_bhq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.in_req_type      (in_ch.data.req_type),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_is_down      (out_ch.data.is_down),
	.out_was_pressed  (out_ch.data.was_pressed),
	.out_was_released (out_ch.data.was_released)
);

>>> dv/button_history_edge_query_test.sv
// button_history_edge_query_test: self-checking bench for the button history block.
// A queue-fed driver sends record and query items, a monitor checks each result
// against a predictor of the history ring; depends on bhq_pkg, bhq_if and the DUT.
`timescale 1ns / 1ps

module button_history_edge_query_test;
	import bhq_pkg::*;

	localparam int HIST_DEPTH   = 64;
	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1830;
	localparam int DRAIN_EVERY  = 500;
	localparam int QUIET_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 200;
	localparam int MAX_HOLD     = 127;
	localparam int MAX_AGO      = 63;
	localparam int MAX_BTN      = 2047;

	// selector code with no control behind it
	localparam logic [SEL_W-1:0] CTL_NONE = 3'd7;

	typedef struct {
		in_item_t item;
		bit       wait_empty;
	} req_entry_t;

	logic clk;
	logic arst_n;

	bhq_in_if  req_ch ();
	bhq_out_if rsp_ch ();

	button_history_edge_query #(
		.DEPTH(HIST_DEPTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch),
		.out_ch (rsp_ch)
	);

	req_entry_t       request_queue [$];
	out_item_t        query_answers [$];
	logic [BTN_W-1:0] frame_hist [HIST_DEPTH];
	int               wr_ptr;
	int               total_items;
	int               accepted_cnt;
	int               results_predicted;
	int               results_checked;
	int               err_count;
	int               phase;
	int               quiet_cycles;

	always #CLK_HALF clk = ~clk;

	// ---------------- predictor ----------------

	function automatic int ctl_index(input logic [SEL_W-1:0] sel);
		case (sel)
			CTL_LEFT:    return int'(BTN_LEFT);
			CTL_RIGHT:   return int'(BTN_RIGHT);
			CTL_DOWN:    return int'(BTN_DOWN);
			CTL_UP:      return int'(BTN_UP);
			CTL_MOVE:    return int'(BTN_MOVE);
			CTL_STANCE1: return int'(BTN_STANCE1);
			CTL_STANCE2: return int'(BTN_STANCE2);
			default:     return -1;
		endcase
	endfunction

	function automatic int slot_back(input int off);
		return (wr_ptr + HIST_DEPTH - (off % HIST_DEPTH)) % HIST_DEPTH;
	endfunction

	function automatic bit ctl_down(input int idx, input int off);
		logic [BTN_W-1:0] snap;
		if (idx < 0)
			return 1'b0;
		snap = frame_hist[slot_back(off)];
		return snap[idx];
	endfunction

	// applies one request to the history copy; returns 1 when it yields an answer
	function automatic bit history_step(input in_item_t req, output out_item_t ans);
		int idx;
		bit now_dn;
		bit prev_dn;
		bit held;
		ans = '0;
		if (req.req_type == REQ_RECORD) begin
			frame_hist[wr_ptr] = req.buttons;
			wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
			return 1'b0;
		end
		idx     = ctl_index(req.control_sel);
		now_dn  = ctl_down(idx, int'(req.frames_ago));
		prev_dn = ctl_down(idx, int'(req.frames_ago) + 1);
		held    = 1'b1;
		for (int i = 0; i < int'(req.hold_length); i++) begin
			if (!ctl_down(idx, int'(req.frames_ago) + i))
				held = 1'b0;
		end
		ans.is_down        = now_dn;
		ans.was_pressed    = now_dn && !prev_dn;
		ans.was_released   = !now_dn && prev_dn;
		ans.was_held       = held;
		ans.latest_buttons = frame_hist[slot_back(1)];
		return 1'b1;
	endfunction

	function automatic int send_idle_pct(input int ph);
		return (ph == 0) ? 9 : (ph == 1) ? 63 : 0;
	endfunction

	function automatic int recv_idle_pct(input int ph);
		return (ph == 0) ? 63 : (ph == 1) ? 9 : 0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
		err_count++;
	endtask

	// ---------------- stimulus helpers ----------------

	task automatic push_req(input logic rt, input int btn, input int sel, input int ago,
			input int hold, input bit wait_empty);
		req_entry_t e;
		e.item.req_type    = rt;
		e.item.buttons     = BTN_W'(btn);
		e.item.control_sel = SEL_W'(sel);
		e.item.frames_ago  = AGO_W'(ago);
		e.item.hold_length = HOLD_W'(hold);
		e.wait_empty       = wait_empty;
		request_queue.push_back(e);
	endtask

	// ignored fields carry random values
	task automatic push_record(input int btn, input bit wait_empty);
		push_req(REQ_RECORD, btn, $urandom_range(0, 7), $urandom_range(0, MAX_AGO),
			$urandom_range(0, MAX_HOLD), wait_empty);
	endtask

	task automatic push_query(input int sel, input int ago, input int hold,
			input bit wait_empty);
		push_req(REQ_QUERY, $urandom_range(0, MAX_BTN), sel, ago, hold, wait_empty);
	endtask

	// ---------------- driver ----------------

	always @(posedge clk or negedge arst_n) begin
		logic      drive;
		int        in_flight;
		out_item_t ans;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
			phase        <= 0;
		end else begin
			drive = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				if (history_step(request_queue[0].item, ans)) begin
					query_answers.push_back(ans);
					results_predicted++;
				end
				void'(request_queue.pop_front());
				accepted_cnt++;
				drive = 1'b0;
			end
			in_flight = results_predicted - results_checked
				- ((rsp_ch.valid && rsp_ch.ready) ? 1 : 0);
			if (!drive && request_queue.size() != 0) begin
				if (request_queue[0].wait_empty && in_flight != 0)
					drive = 1'b0;
				else
					drive = ($urandom_range(0, 99) >= send_idle_pct(phase));
			end
			req_ch.valid <= drive;
			if (drive)
				req_ch.data <= request_queue[0].item;
			if (accepted_cnt * 3 < total_items)
				phase <= 0;
			else if (accepted_cnt * 3 < total_items * 2)
				phase <= 1;
			else
				phase <= 2;
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			rsp_ch.ready    <= 1'b0;
			results_checked <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (query_answers.size() == 0) begin
					report_mismatch("result with nothing pending", int'(got), 0);
				end else begin
					want = query_answers.pop_front();
					if (got.is_down !== want.is_down)
						report_mismatch("is_down", int'(got.is_down),
							int'(want.is_down));
					if (got.was_pressed !== want.was_pressed)
						report_mismatch("was_pressed", int'(got.was_pressed),
							int'(want.was_pressed));
					if (got.was_released !== want.was_released)
						report_mismatch("was_released", int'(got.was_released),
							int'(want.was_released));
					if (got.was_held !== want.was_held)
						report_mismatch("was_held", int'(got.was_held),
							int'(want.was_held));
					if (got.latest_buttons !== want.latest_buttons)
						report_mismatch("latest_buttons", int'(got.latest_buttons),
							int'(want.latest_buttons));
				end
				results_checked <= results_checked + 1;
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct(phase));
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int cur_btn;
		int burst;
		int hold;
		int ago;
		int flips;
		clk               = 1'b0;
		arst_n            = 1'b0;
		wr_ptr            = 0;
		accepted_cnt      = 0;
		results_predicted = 0;
		err_count         = 0;
		for (int i = 0; i < HIST_DEPTH; i++)
			frame_hist[i] = '0;

		// history still clear after reset
		push_query(int'(CTL_LEFT), 0, 0, 1'b0);
		push_record(MAX_BTN, 1'b0);
		push_record(MAX_BTN, 1'b0);
		push_record(0, 1'b0);
		push_record(MAX_BTN, 1'b0);
		// newest frame all down, one earlier all up: every control
		for (int s = 0; s <= int'(CTL_NONE); s++)
			push_query(s, 0, 2, 1'b0);
		push_query(int'(CTL_LEFT), 1, 1, 1'b0);
		// deepest offset and longest hold, both wrapping the ring
		push_query(int'(CTL_RIGHT), MAX_AGO, MAX_HOLD, 1'b0);
		push_query(int'(CTL_STANCE2), 0, HIST_DEPTH, 1'b0);
		push_query(int'(CTL_NONE), MAX_AGO, 0, 1'b0);
		push_record(0, 1'b0);
		push_query(int'(CTL_UP), 0, 0, 1'b0);

		cur_btn = 0;
		while (request_queue.size() < RANDOM_ITEMS + 19) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: anything at all
				push_req(1'($urandom_range(0, 1)), $urandom_range(0, MAX_BTN),
					$urandom_range(0, 7), $urandom_range(0, MAX_AGO),
					$urandom_range(0, MAX_HOLD),
					(request_queue.size() % DRAIN_EVERY) == 0);
			end else begin
				// a few frames of slowly changing buttons, then a few queries
				burst = $urandom_range(1, 8);
				for (int b = 0; b < burst; b++) begin
					if ($urandom_range(0, 9) == 0) begin
						cur_btn = $urandom_range(0, MAX_BTN);
					end else begin
						flips = 0;
						for (int k = 0; k < BTN_W; k++)
							if ($urandom_range(0, 7) == 0)
								flips |= (1 << k);
						cur_btn ^= flips;
					end
					push_record(cur_btn, (request_queue.size() % DRAIN_EVERY) == 0);
				end
				burst = $urandom_range(1, 4);
				for (int q = 0; q < burst; q++) begin
					case ($urandom_range(0, 9))
						0:       hold = $urandom_range(0, MAX_HOLD);
						1, 2, 3: hold = $urandom_range(0, HIST_DEPTH);
						default: hold = $urandom_range(0, 6);
					endcase
					ago = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7)
						: $urandom_range(0, MAX_AGO);
					push_query($urandom_range(0, 7), ago, hold,
						(request_queue.size() % DRAIN_EVERY) == 0);
				end
			end
		end
		total_items = request_queue.size();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_queue.size() != 0 || req_ch.valid || query_answers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (query_answers.size() != 0)
			report_mismatch("answers never returned", 0, query_answers.size());

		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
